// ===== hw/rtl/esf_pkg.sv =====
// shared types and constants of the eta smoothing filter
package esf_pkg;

  // fixed field widths
  localparam int TIME_W  = 32;
  localparam int RAW_W   = 32;
  localparam int SHOWN_W = 31;
  localparam int MUL_A_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int TAU_W      = 16;
  localparam int DBA_W      = 16;
  localparam int DBR_W      = 16;
  localparam int JA_W       = 20;
  localparam int JR_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONSTANT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_ABSOLUTE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_RELATIVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_ABSOLUTE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_RELATIVE     = 3'd4;

  // register reset values
  localparam logic [TAU_W-1:0] TAU_RST = 16'd256;
  localparam logic [DBA_W-1:0] DBA_RST = 16'd205;
  localparam logic [DBR_W-1:0] DBR_RST = 16'd655;
  localparam logic [JA_W-1:0]  JA_RST  = 20'd2560;
  localparam logic [JR_W-1:0]  JR_RST  = 16'd19661;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EVAL   = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_POST1  = 7'b0010000,
    ST_POST2  = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_e;

  // multiplier schedule: a step issues a product, the next step takes it
  typedef enum logic [2:0] {
    MS_DT_LO = 3'd0,
    MS_DT_HI = 3'd1,
    MS_TAU   = 3'd2,
    MS_DBR   = 3'd3,
    MS_JR    = 3'd4,
    MS_LAST  = 3'd5
  } mul_step_e;

endpackage

// ===== hw/rtl/esf_stream_if.sv =====
// valid/ready stream interfaces for input and result words
interface esf_in_if import esf_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        sample_time;
  logic signed [RAW_W-1:0]  raw_estimate;

  modport source (output valid, output sample_time, output raw_estimate, input ready);
  modport sink   (input valid, input sample_time, input raw_estimate, output ready);
endinterface

interface esf_out_if import esf_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [SHOWN_W-1:0]   shown_estimate;

  modport source (output valid, output shown_estimate, input ready);
  modport sink   (input valid, input shown_estimate, output ready);
endinterface

// ===== hw/rtl/esf_mul.sv =====
// shared registered 16 by N bit multiplier
module esf_mul import esf_pkg::*;
#(
  parameter int BW = 39
) (
  input  logic                   clk_i,
  input  logic [MUL_A_W-1:0]     a_i,
  input  logic [BW-1:0]          b_i,
  output logic [MUL_A_W+BW-1:0]  p_o
);

  logic [MUL_A_W+BW-1:0] p_q;

  // one product per cycle, registered result
  always_ff @(posedge clk_i) begin
    p_q <= (MUL_A_W+BW)'(a_i) * (MUL_A_W+BW)'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/esf_div.sv =====
// restoring divider, one quotient bit per cycle
module esf_div #(
  parameter int QW = 39,
  parameter int DW = 41
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QW+DW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic             done_o,
  output logic [QW-1:0]    quo_o
);

  localparam int CW = (QW > 1) ? $clog2(QW) : 1;

  logic [DW-1:0] rem_q;
  logic [QW-1:0] low_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          fits;

  // trial subtraction of the divisor from the shifted remainder
  assign trial = {rem_q, low_q[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign fits  = ~diff[DW+1];

  // datapath: quotient bits shift in where numerator bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[QW+DW-1:QW];
      low_q <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
      low_q <= {low_q[QW-2:0], fits};
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= CW'(QW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
          cnt_q  <= cnt_q - 1'b1;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = low_q;

endmodule

// ===== hw/rtl/eta_smoothing_filter_top.sv =====
// eta smoothing filter: sequencer, state and post-processing around shared units
// Trivial words (raw not positive, first sample, time not after the last one) go
// from evaluation straight to the result state; others take six multiplier steps,
// the one-bit-per-cycle divider (31+FRACTION_BITS steps), ST_POST1 and ST_POST2.
// One word at a time, the next taken in idle once the result is registered.
// Asynchronous reset clears the held estimate and restores register defaults.
module eta_smoothing_filter_top import esf_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  esf_in_if.sink                in_i,
  esf_out_if.source             out_o
);

  localparam int HW  = 31 + FRACTION_BITS;     // held value
  localparam int DTW = 32 + FRACTION_BITS;     // elapsed time in fixed point
  localparam int DW  = 33 + FRACTION_BITS;     // divisor
  localparam int NW  = 64 + 2 * FRACTION_BITS; // numerator
  localparam int PW  = MUL_A_W + HW;           // multiplier product
  localparam int SW  = DTW + 2;                // signed floor compare
  localparam int ACW = 63;                     // dt times raw

  // configuration registers
  logic [TAU_W-1:0] cfg_tau_q;
  logic [DBA_W-1:0] cfg_dba_q;
  logic [DBR_W-1:0] cfg_dbr_q;
  logic [JA_W-1:0]  cfg_ja_q;
  logic [JR_W-1:0]  cfg_jr_q;

  // filter state
  logic [HW-1:0]     held_q;
  logic              have_q;
  logic [TIME_W-1:0] prev_q;

  // word in work
  state_e            state_q, state_d;
  mul_step_e         mstep_q;
  logic [TIME_W-1:0] now_q;
  logic [RAW_W-1:0]  raw_q;
  logic [TIME_W-1:0] dt_q;
  logic [ACW-1:0]    acc_q;
  logic [NW-1:0]     num_q;
  logic [PW-1:0]     held_dbr_q;
  logic [PW-1:0]     held_jr_q;
  logic [HW-1:0]     v2_q;
  logic [HW-1:0]     new_held_q;
  logic              upd_q;
  logic              zero_q;

  // result register
  logic               out_valid_q;
  logic [SHOWN_W-1:0] out_data_q;

  logic               out_free;
  logic [HW-1:0]      rawq;
  logic [DTW-1:0]     dtq;
  logic [DW-1:0]      den;

  logic [MUL_A_W-1:0] mul_a;
  logic [HW-1:0]      mul_b;
  logic [PW-1:0]      mul_p;

  logic               div_start;
  logic               div_done;
  logic [HW-1:0]      quo;

  logic [HW-1:0]      dev_avg;
  logic [HW-1:0]      dev_raw;
  logic               in_deadband;
  logic               is_jump;
  logic [HW-1:0]      v1;
  logic [HW-1:0]      v2;
  logic signed [SW-1:0] floor_s;
  logic signed [SW-1:0] v2_s;
  logic signed [SW-1:0] rawq_s;
  logic [HW-1:0]      v3;

  assign rawq     = {raw_q[SHOWN_W-1:0], {FRACTION_BITS{1'b0}}};
  assign dtq      = {dt_q, {FRACTION_BITS{1'b0}}};
  assign den      = DW'(cfg_tau_q) + DW'(dtq);
  assign out_free = ~out_valid_q | out_o.ready;

  // shared units
  esf_mul #(.BW(HW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  esf_div #(.QW(HW), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // multiplier operand selection per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mstep_q)
      MS_DT_LO: begin
        mul_a = dt_q[15:0];
        mul_b = HW'(raw_q[SHOWN_W-1:0]);
      end
      MS_DT_HI: begin
        mul_a = dt_q[31:16];
        mul_b = HW'(raw_q[SHOWN_W-1:0]);
      end
      MS_TAU: begin
        mul_a = cfg_tau_q;
        mul_b = held_q;
      end
      MS_DBR: begin
        mul_a = cfg_dbr_q;
        mul_b = held_q;
      end
      MS_JR: begin
        mul_a = cfg_jr_q;
        mul_b = held_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start = (state_q == ST_MUL) && (mstep_q == MS_LAST);

  // deadband rule on the quotient, jump rule on the raw value
  always_comb begin
    dev_avg     = (held_q > quo) ? held_q - quo : quo - held_q;
    in_deadband = (dev_avg < HW'(cfg_dba_q)) ||
                  ({dev_avg, 16'h0000} < held_dbr_q);
    v1          = in_deadband ? held_q : quo;
    dev_raw     = (held_q > rawq) ? held_q - rawq : rawq - held_q;
    is_jump     = (dev_raw > HW'(cfg_ja_q)) &&
                  ({dev_raw, 16'h0000} > held_jr_q);
    v2          = is_jump ? rawq : v1;
  end

  // minimum descent, clamped at raw where the floor applies
  always_comb begin
    floor_s = $signed(SW'(held_q)) - $signed(SW'(dtq));
    v2_s    = $signed(SW'(v2_q));
    rawq_s  = $signed(SW'(rawq));
    if (v2_s > floor_s) begin
      v3 = (floor_s > rawq_s) ? floor_s[HW-1:0] : rawq;
    end else begin
      v3 = v2_q;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if ((raw_q == '0) || raw_q[RAW_W-1] || !have_q || (now_q <= prev_q)) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mstep_q == MS_LAST) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_POST1;
      end
      ST_POST1: state_d = ST_POST2;
      ST_POST2: state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mstep_q <= MS_DT_LO;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MUL) begin
        case (mstep_q)
          MS_DT_LO: mstep_q <= MS_DT_HI;
          MS_DT_HI: mstep_q <= MS_TAU;
          MS_TAU:   mstep_q <= MS_DBR;
          MS_DBR:   mstep_q <= MS_JR;
          MS_JR:    mstep_q <= MS_LAST;
          default:  mstep_q <= MS_DT_LO;
        endcase
      end else begin
        mstep_q <= MS_DT_LO;
      end
    end
  end

  // word datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        now_q <= in_i.sample_time;
        raw_q <= in_i.raw_estimate;
      end
      ST_EVAL: begin
        dt_q   <= now_q - prev_q;
        zero_q <= (raw_q == '0) || raw_q[RAW_W-1];
        if (!have_q) begin
          new_held_q <= rawq;
          upd_q      <= ~((raw_q == '0) || raw_q[RAW_W-1]);
        end else begin
          new_held_q <= held_q;
          upd_q      <= 1'b0;
        end
      end
      ST_MUL: begin
        // each step after the first takes the registered product of the step before
        case (mstep_q)
          MS_DT_HI: acc_q      <= ACW'(mul_p);
          MS_TAU:   acc_q      <= acc_q + (ACW'(mul_p) << 16);
          MS_DBR:   num_q      <= (NW'(acc_q) << (2 * FRACTION_BITS)) + NW'(mul_p);
          MS_JR:    held_dbr_q <= mul_p;
          MS_LAST:  held_jr_q  <= mul_p;
          default:  ;
        endcase
      end
      ST_POST1: v2_q <= v2;
      ST_POST2: begin
        new_held_q <= v3;
        upd_q      <= 1'b1;
      end
      default: ;
    endcase
  end

  // filter state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      have_q      <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if ((state_q == ST_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= zero_q ? '0 : new_held_q[HW-1:FRACTION_BITS];
        if (upd_q) begin
          held_q <= new_held_q;
          have_q <= 1'b1;
          prev_q <= now_q;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.shown_estimate = out_data_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_tau_q <= TAU_RST;
      cfg_dba_q <= DBA_RST;
      cfg_dbr_q <= DBR_RST;
      cfg_ja_q  <= JA_RST;
      cfg_jr_q  <= JR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_CONSTANT:     cfg_tau_q <= cfg_wdata_i[TAU_W-1:0];
        CFG_DEADBAND_ABSOLUTE: cfg_dba_q <= cfg_wdata_i[DBA_W-1:0];
        CFG_DEADBAND_RELATIVE: cfg_dbr_q <= cfg_wdata_i[DBR_W-1:0];
        CFG_JUMP_ABSOLUTE:     cfg_ja_q  <= cfg_wdata_i[JA_W-1:0];
        CFG_JUMP_RELATIVE:     cfg_jr_q  <= cfg_wdata_i[JR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
